/* rtl/float_add_subtract_top_macros.svh */
// Assertion macros used by the checker file.
`ifndef FLOAT_ADD_SUBTRACT_TOP_MACROS_SVH
`define FLOAT_ADD_SUBTRACT_TOP_MACROS_SVH
// Implication check with reset disable.
`define FAS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication check with reset disable.
`define FAS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/fas_pkg.sv */
// ----------------------------------------------------------------------------
// fas_pkg
// Constants and types for the single-precision add/subtract pipeline.
// ----------------------------------------------------------------------------
package fas_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned ManW  = 24;
  localparam int unsigned SumW  = 25;
  localparam int unsigned ShW   = 5;

  typedef enum logic {
    REQ_ADD = 1'b0,
    REQ_SUB = 1'b1
  } req_e;
endpackage

/* rtl/float_add_subtract_top.sv */
// ----------------------------------------------------------------------------
// float_add_subtract_top
// Single-precision adder/subtractor, four register stages, truncating.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                Fields
// in       input      in_valid_i / in_stall_o  req_type_i, operand_a_i, operand_b_i
// out      output     out_valid_o / out_stall_i sum_word_o
//
// One word accepted per cycle while in_stall_o is low; each word passes stages 1 to 4 to out_valid_o.
// Stages: swap/compare, align shift, add/subtract, leading-one normalize.
// Every stage holds while the stage after it is full and stalled.
// Reset clears only the stage valid bits.
module float_add_subtract_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] sum_word_o
);
  logic [3:0] vld_q;
  logic [3:0] adv;

  // stage 1 regs
  logic        s1_sb_q, s1_diff_q, s1_bzero_q, s1_szero_q;
  logic [7:0]  s1_eb_q, s1_gap_q;
  logic [22:0] s1_fb_q, s1_fs_q;
  // stage 2
  logic        s2_sb_q, s2_diff_q;
  logic [7:0]  s2_eb_q;
  logic [23:0] s2_mb_q, s2_ms_q;
  // stage 3
  logic        s3_sb_q;
  logic [7:0]  s3_eb_q;
  logic [24:0] s3_sum_q;
  // stage 4
  logic [31:0] s4_word_q;

  // a stage may load when it is empty or its contents move on
  assign adv[3] = !vld_q[3] || !out_stall_i;
  assign adv[2] = !vld_q[2] || adv[3];
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[3];
  assign sum_word_o  = s4_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
    end
  end

  // stage 1: compare magnitudes, pick big/small
  logic        sa, sb, abig;
  logic [7:0]  ea, eb, ebig, esml;
  logic [22:0] fa, fb;
  always_comb begin
    sa = operand_a_i[31];
    sb = operand_b_i[31] ^ (req_type_i == fas_pkg::REQ_SUB);
    ea = operand_a_i[30:23];
    eb = operand_b_i[30:23];
    fa = operand_a_i[22:0];
    fb = operand_b_i[22:0];
    abig = (ea == eb) ? (fa >= fb) : (ea > eb);
    ebig = abig ? ea : eb;
    esml = abig ? eb : ea;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      s1_sb_q    <= abig ? sa : sb;
      s1_diff_q  <= sa ^ sb;
      s1_eb_q    <= ebig;
      s1_gap_q   <= ebig - esml;
      s1_fb_q    <= abig ? fa : fb;
      s1_fs_q    <= abig ? fb : fa;
      s1_bzero_q <= (ebig == '0);
      s1_szero_q <= (esml == '0);
    end
  end

  // stage 2: align
  always_ff @(posedge clk_i) begin
    if (adv[1] && vld_q[0]) begin
      s2_sb_q   <= s1_sb_q;
      s2_diff_q <= s1_diff_q;
      s2_eb_q   <= s1_eb_q;
      s2_mb_q   <= s1_bzero_q ? '0 : {1'b1, s1_fb_q};
      s2_ms_q   <= (s1_szero_q || s1_gap_q >= 8'd24) ? '0
                   : ({1'b1, s1_fs_q} >> s1_gap_q[4:0]);
    end
  end

  // stage 3: add or subtract
  always_ff @(posedge clk_i) begin
    if (adv[2] && vld_q[1]) begin
      s3_sb_q  <= s2_sb_q;
      s3_eb_q  <= s2_eb_q;
      s3_sum_q <= s2_diff_q ? ({1'b0, s2_mb_q} - {1'b0, s2_ms_q})
                            : ({1'b0, s2_mb_q} + {1'b0, s2_ms_q});
    end
  end

  // stage 4: find leading one, normalize, pack
  logic [4:0]  sh;
  logic [24:0] norm;
  logic [8:0]  top;
  always_comb begin
    sh = 5'd0;
    for (int i = 0; i < 25; i++) begin
      if (s3_sum_q[i]) sh = 5'(24 - i);
    end
    norm = s3_sum_q << sh;
    top  = {s3_sb_q, 8'd0} + {1'b0, s3_eb_q} + 9'd1 - {4'd0, sh};
  end

  always_ff @(posedge clk_i) begin
    if (adv[3] && vld_q[2]) begin
      s4_word_q <= (s3_sum_q == '0) ? '0 : {top, norm[23:1]};
    end
  end
endmodule

/* rtl/fas_checker.sv */
// ----------------------------------------------------------------------------
// fas_checker
// Port-level checks on the add/subtract pipeline.
// ----------------------------------------------------------------------------
`include "float_add_subtract_top_macros.svh"
module fas_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] sum_word_o
);
  `FAS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(sum_word_o), "stalled word changed")
  `FAS_ASSERT_IMP(a_no_stall_free, clk_i, rst_ni, !out_valid_o, !in_stall_o, "input stalled with empty output")
  `FAS_ASSERT_IMP(a_flow, clk_i, rst_ni, !out_stall_i, !in_stall_o, "input stalled without output stall")
endmodule

bind float_add_subtract_top fas_checker u_fas_checker (.*);

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Random and directed test of the single-precision add/subtract pipeline.
// Words are predicted at accept time and checked in order at the output.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned NumRandom = 1850;
  localparam int unsigned WatchLimit = 5000;

  // --------------------------------------------------------------------------
  // expected sums, oldest first
  // --------------------------------------------------------------------------
  class sum_scoreboard;
    logic [31:0] pending_sums[$];
    int unsigned n_errors;
    int unsigned n_checked;

    // truncating single-precision add, zero exponent as zero, wrapping exponent
    function automatic logic [31:0] fp_sum(fas_pkg::req_e op, logic [31:0] a,
                                           logic [31:0] b_in);
      logic [31:0] b;
      logic sa, sb, s_big, s_small, a_big;
      logic [7:0] ea, eb, e_big, e_small;
      logic [22:0] fa, fb, f_big, f_small;
      logic [23:0] m_big, m_small;
      logic [24:0] sum;
      logic [22:0] frac;
      logic [8:0] top;
      int p;
      int unsigned gap;
      b = b_in;
      if (op == fas_pkg::REQ_SUB) b[31] = ~b[31];
      {sa, ea, fa} = a;
      {sb, eb, fb} = b;
      a_big = (ea == eb) ? (fa >= fb) : (ea > eb);
      s_big = a_big ? sa : sb;
      e_big = a_big ? ea : eb;
      f_big = a_big ? fa : fb;
      s_small = a_big ? sb : sa;
      e_small = a_big ? eb : ea;
      f_small = a_big ? fb : fa;
      m_big = (e_big == 0) ? 24'd0 : {1'b1, f_big};
      gap = e_big - e_small;
      m_small = '0;
      if (e_small != 0 && gap < 24) m_small = {1'b1, f_small} >> gap;
      if (s_big ^ s_small) sum = {1'b0, m_big} - {1'b0, m_small};
      else sum = {1'b0, m_big} + {1'b0, m_small};
      if (sum == 0) return 32'd0;
      p = 24;
      while (!sum[p]) p--;
      if (p == 24) frac = sum[23:1];
      else frac = 23'(sum << (23 - p));
      top = {s_big, 8'd0} + {1'b0, e_big} + 9'd1 - 9'(24 - p);
      return {top, frac};
    endfunction

    function void note_input(fas_pkg::req_e op, logic [31:0] a, logic [31:0] b);
      pending_sums.push_back(fp_sum(op, a, b));
    endfunction

    function void check_sum(logic [31:0] got);
      logic [31:0] want;
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got));
        return;
      end
      want = pending_sums.pop_front();
      n_checked++;
      if (got !== want)
        report_mismatch($sformatf("sum_word got %h want %h", got, want));
    endfunction

    function void report_mismatch(string msg);
      n_errors++;
      if (n_errors <= 40) $display("MISMATCH %0t: %s", $time, msg);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = 1'b0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] sum_word_o;

  sum_scoreboard sb = new();
  bit calm = 1'b0;  // no idling on either side
  int unsigned idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  float_add_subtract_top dut (.*);

  // receiver: random stall, check on accept
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_sum(sum_word_o);
      out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 36);
    end
  end

  // watchdog on cycles without any accept
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog: no progress for %0d cycles", WatchLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(fas_pkg::req_e op, logic [31:0] a, logic [31:0] b);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(op, a, b);
  endtask

  function automatic logic [31:0] rand_float();
    logic [7:0] e;
    case ($urandom_range(9))
      0: e = 8'd0;
      1: e = 8'd255;
      2: e = 8'd1;
      3: e = 8'd254;
      default: e = 8'($urandom_range(100, 154));
    endcase
    return {1'($urandom), e, 23'($urandom)};
  endfunction

  task automatic send_random();
    logic [31:0] a, b;
    fas_pkg::req_e op;
    a = rand_float();
    op = fas_pkg::req_e'($urandom_range(1));
    case ($urandom_range(5))
      0: b = a;                                       // exact cancel or double
      1: b = {a[31:23] ^ 9'($urandom_range(3)), 23'($urandom)};  // near exponent
      2: b = {1'($urandom), 8'(a[30:23] + $urandom_range(20, 30)), 23'($urandom)};
      3: b = $urandom();
      default: b = rand_float();
    endcase
    if ($urandom_range(1)) send_word(op, a, b);
    else send_word(op, b, a);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero exponents, large gaps, cancellation, wrap
    send_word(fas_pkg::REQ_ADD, 32'h0000_0000, 32'h0000_0000);
    send_word(fas_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(fas_pkg::REQ_SUB, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_word(fas_pkg::REQ_ADD, 32'h3F80_0000, 32'h3F80_0000);
    send_word(fas_pkg::REQ_SUB, 32'h3F80_0000, 32'h3F80_0000);
    send_word(fas_pkg::REQ_ADD, 32'h007F_FFFF, 32'h3F80_0000);
    send_word(fas_pkg::REQ_ADD, 32'h3F80_0000, 32'h807F_FFFF);
    send_word(fas_pkg::REQ_ADD, 32'h3F80_0000, 32'h3380_0000);  // gap of 24
    send_word(fas_pkg::REQ_ADD, 32'h3F80_0000, 32'h3400_0000);  // gap of 23
    send_word(fas_pkg::REQ_ADD, 32'h7F80_0000, 32'h0080_0000);  // gap of 254
    send_word(fas_pkg::REQ_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);  // exponent overflow to 255
    send_word(fas_pkg::REQ_SUB, 32'h0080_0001, 32'h0080_0000);  // exponent underflow wrap
    send_word(fas_pkg::REQ_SUB, 32'h3F80_0000, 32'h3F7F_FFFF);
    send_word(fas_pkg::REQ_SUB, 32'h4000_0000, 32'hBF80_0000);
    send_word(fas_pkg::REQ_ADD, 32'hC000_0000, 32'h3FFF_FFFF);
    send_word(fas_pkg::REQ_SUB, 32'h0000_0000, 32'h4120_0000);
    send_word(fas_pkg::REQ_ADD, 32'h5555_5555, 32'hAAAA_AAAA);
    send_word(fas_pkg::REQ_SUB, 32'hAAAA_AAAA, 32'h5555_5555);

    for (int i = 0; i < NumRandom; i++) begin
      calm = (i >= 700 && i < 900);
      if (i == 1000) begin
        // hold off until the pipe drains
        in_valid_i <= 1'b0;
        while (sb.pending_sums.size() != 0) @(posedge clk_i);
      end
      send_random();
    end
    in_valid_i <= 1'b0;

    while (sb.pending_sums.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d sums: add and subtract, zero and max exponents, wide gaps,",
             sb.n_checked);
    $display("cancellation and exponent wrap, with random stalls on both sides");
    if (sb.n_errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl
rtl/fas_pkg.sv
rtl/float_add_subtract_top.sv
rtl/fas_checker.sv
verif/tb_top.sv
